// ===== rtl/core/erac_pkg.sv =====
`timescale 1ns / 1ps
package erac_pkg;

    localparam int QF = 24;
    localparam int AW = 30;
    localparam int ATAN_LEN = 24;

    localparam logic signed [AW-1:0] Q_PI      = AW'(52707179);
    localparam logic signed [AW-1:0] Q_HALF_PI = AW'(26353589);
    localparam logic signed [AW-1:0] Q_TWO_PI  = AW'(105414357);
    localparam logic signed [AW-1:0] Q_GAIN    = AW'(10188014);
    localparam logic signed [16:0]   PIVOT     = 17'sd8192;

    typedef enum logic [0:0] {
        MODE_ANGLE  = 1'b0,
        MODE_VERTEX = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CORDIC,
        ST_MUL,
        ST_DONE
    } ang_state_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] a_x;
        logic [15:0] a_y;
        logic [15:0] a_z;
        logic [15:0] v_x;
        logic [15:0] v_y;
        logic [15:0] v_z;
    } item_t;

    function automatic logic signed [AW-1:0] atan_q24(input logic [4:0] i);
        logic signed [AW-1:0] r;
        begin
            case (i)
                5'd0:  r = AW'(13176795);
                5'd1:  r = AW'(7778716);
                5'd2:  r = AW'(4110060);
                5'd3:  r = AW'(2086331);
                5'd4:  r = AW'(1047214);
                5'd5:  r = AW'(524117);
                5'd6:  r = AW'(262123);
                5'd7:  r = AW'(131069);
                5'd8:  r = AW'(65536);
                5'd9:  r = AW'(32768);
                5'd10: r = AW'(16384);
                5'd11: r = AW'(8192);
                5'd12: r = AW'(4096);
                5'd13: r = AW'(2048);
                5'd14: r = AW'(1024);
                5'd15: r = AW'(512);
                5'd16: r = AW'(256);
                5'd17: r = AW'(128);
                5'd18: r = AW'(64);
                5'd19: r = AW'(32);
                5'd20: r = AW'(16);
                5'd21: r = AW'(8);
                5'd22: r = AW'(4);
                5'd23: r = AW'(2);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/erac_front.sv =====
`timescale 1ns / 1ps
// Two-entry queue; in_stall rises only when both entries are full.
module erac_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  erac_pkg::item_t   in_item,
    output logic              q_valid,
    input  logic              q_take,
    output erac_pkg::item_t   q_item
);

    erac_pkg::item_t mem_reg [2];
    logic            wp_reg, rp_reg;
    logic [1:0]      cnt_reg;
    logic            push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (q_take)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_take);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

endmodule

// ===== rtl/core/erac_angle.sv =====
`timescale 1ns / 1ps
// Angle unit: one shared CORDIC runs the three angles in turn, then one
// shared multiplier forms the products of the matrix, one per cycle.
module erac_angle #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 14
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [15:0]           ang_x,
    input  logic signed [15:0]           ang_y,
    input  logic signed [15:0]           ang_z,
    output logic                         busy,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] ent [9]
);

    localparam int AW    = erac_pkg::AW;
    localparam int STEPS = (CORDIC_STEPS > erac_pkg::ATAN_LEN) ? erac_pkg::ATAN_LEN
                                                               : CORDIC_STEPS;
    localparam int FB    = DATA_WIDTH - 2;
    localparam int EW    = AW + 10;

    erac_pkg::ang_state_t state_reg, state_next;
    logic signed [15:0]   ang_reg [3];
    logic [1:0]           ai_reg, ai_next;
    logic [4:0]           it_reg, it_next;
    logic [3:0]           mi_reg, mi_next;
    logic signed [AW-1:0] x_reg, y_reg, z_reg;
    logic                 ncos_reg;
    logic signed [AW-1:0] c_reg [3];
    logic signed [AW-1:0] s_reg [3];
    logic signed [AW-1:0] p_reg [14];
    logic signed [DATA_WIDTH-1:0] ent_reg [9];

    logic signed [AW-1:0] a_full, a_red, dx, dy;
    logic signed [AW-1:0] ma, mb, prod;
    logic signed [2*AW-1:0] full;

    function automatic logic signed [DATA_WIDTH-1:0] to_entry(input logic signed [AW-1:0] v);
        logic signed [EW-1:0] r;
        logic signed [EW-1:0] hi, lo;
        begin
            if (FB <= erac_pkg::QF)
            begin
                if (FB == erac_pkg::QF)
                    r = EW'(v);
                else
                    r = (EW'(v) + (EW'(1) <<< (erac_pkg::QF - FB - 1)))
                        >>> (erac_pkg::QF - FB);
            end
            else
                r = EW'(v) <<< (FB - erac_pkg::QF);
            hi = (EW'(1) <<< (DATA_WIDTH - 1)) - EW'(1);
            lo = -hi - EW'(1);
            if (r > hi)
                r = hi;
            else if (r < lo)
                r = lo;
            return DATA_WIDTH'(r);
        end
    endfunction

    always_comb
    begin
        a_full = AW'(ang_reg[ai_reg]) <<< 12;
        if (a_full >= erac_pkg::Q_PI)
            a_red = a_full - erac_pkg::Q_TWO_PI;
        else if (a_full < -erac_pkg::Q_PI)
            a_red = a_full + erac_pkg::Q_TWO_PI;
        else
            a_red = a_full;
        dx = y_reg >>> it_reg;
        dy = x_reg >>> it_reg;
    end

    // Product schedule: 0 czcy,1 czsy,2 szsy,3 szcx,4 szcy,5 czcx,6 czsx,
    // 7 cysx,8 cycx, 9 czsy*sx,10 czsy*cx,11 szsy*sx,12 szsy*cx,13 szsx.
    always_comb
    begin
        case (mi_reg)
            4'd0:    begin ma = c_reg[2]; mb = c_reg[1]; end
            4'd1:    begin ma = c_reg[2]; mb = s_reg[1]; end
            4'd2:    begin ma = s_reg[2]; mb = s_reg[1]; end
            4'd3:    begin ma = s_reg[2]; mb = c_reg[0]; end
            4'd4:    begin ma = s_reg[2]; mb = c_reg[1]; end
            4'd5:    begin ma = c_reg[2]; mb = c_reg[0]; end
            4'd6:    begin ma = c_reg[2]; mb = s_reg[0]; end
            4'd7:    begin ma = c_reg[1]; mb = s_reg[0]; end
            4'd8:    begin ma = c_reg[1]; mb = c_reg[0]; end
            4'd9:    begin ma = p_reg[1]; mb = s_reg[0]; end
            4'd10:   begin ma = p_reg[1]; mb = c_reg[0]; end
            4'd11:   begin ma = p_reg[2]; mb = s_reg[0]; end
            4'd12:   begin ma = p_reg[2]; mb = c_reg[0]; end
            4'd13:   begin ma = s_reg[2]; mb = s_reg[0]; end
            default: begin ma = '0; mb = '0; end
        endcase
        full = ma * mb;
        prod = AW'((full + (2*AW)'(1 << (erac_pkg::QF - 1))) >>> erac_pkg::QF);
    end

    always_comb
    begin
        state_next = state_reg;
        ai_next    = ai_reg;
        it_next    = it_reg;
        mi_next    = mi_reg;
        done       = 1'b0;
        case (state_reg)
            erac_pkg::ST_IDLE:
                if (start)
                begin
                    state_next = erac_pkg::ST_REDUCE;
                    ai_next    = 2'd0;
                end
            erac_pkg::ST_REDUCE:
            begin
                state_next = erac_pkg::ST_CORDIC;
                it_next    = 5'd0;
            end
            erac_pkg::ST_CORDIC:
                if (it_reg == 5'(STEPS))
                begin
                    if (ai_reg == 2'd2)
                    begin
                        state_next = erac_pkg::ST_MUL;
                        mi_next    = 4'd0;
                    end
                    else
                    begin
                        state_next = erac_pkg::ST_REDUCE;
                        ai_next    = ai_reg + 2'd1;
                    end
                end
                else
                    it_next = it_reg + 5'd1;
            erac_pkg::ST_MUL:
                if (mi_reg == 4'd13)
                    state_next = erac_pkg::ST_DONE;
                else
                    mi_next = mi_reg + 4'd1;
            erac_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = erac_pkg::ST_IDLE;
            end
            default: state_next = erac_pkg::ST_IDLE;
        endcase
    end

    assign busy = (state_reg != erac_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erac_pkg::ST_IDLE;
            ai_reg    <= 2'd0;
            it_reg    <= 5'd0;
            mi_reg    <= 4'd0;
            for (int i = 0; i < 9; i++)
                ent_reg[i] <= (i % 4 == 0) ? DATA_WIDTH'(1 << (DATA_WIDTH - 2)) : '0;
        end
        else
        begin
            state_reg <= state_next;
            ai_reg    <= ai_next;
            it_reg    <= it_next;
            mi_reg    <= mi_next;
            if (state_reg == erac_pkg::ST_DONE)
            begin
                ent_reg[0] <= to_entry(p_reg[0]);
                ent_reg[1] <= to_entry(p_reg[9] - p_reg[3]);
                ent_reg[2] <= to_entry(p_reg[10] + p_reg[13]);
                ent_reg[3] <= to_entry(p_reg[4]);
                ent_reg[4] <= to_entry(p_reg[11] + p_reg[5]);
                ent_reg[5] <= to_entry(p_reg[12] - p_reg[6]);
                ent_reg[6] <= to_entry(-s_reg[1]);
                ent_reg[7] <= to_entry(p_reg[7]);
                ent_reg[8] <= to_entry(p_reg[8]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == erac_pkg::ST_IDLE)
        begin
            ang_reg[0] <= ang_x;
            ang_reg[1] <= ang_y;
            ang_reg[2] <= ang_z;
        end
        case (state_reg)
            erac_pkg::ST_REDUCE:
            begin
                x_reg <= erac_pkg::Q_GAIN;
                y_reg <= '0;
                if (a_red > erac_pkg::Q_HALF_PI)
                begin
                    z_reg    <= erac_pkg::Q_PI - a_red;
                    ncos_reg <= 1'b1;
                end
                else if (a_red < -erac_pkg::Q_HALF_PI)
                begin
                    z_reg    <= -erac_pkg::Q_PI - a_red;
                    ncos_reg <= 1'b1;
                end
                else
                begin
                    z_reg    <= a_red;
                    ncos_reg <= 1'b0;
                end
            end
            erac_pkg::ST_CORDIC:
                if (it_reg == 5'(STEPS))
                begin
                    c_reg[ai_reg] <= ncos_reg ? -x_reg : x_reg;
                    s_reg[ai_reg] <= y_reg;
                end
                else if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - erac_pkg::atan_q24(it_reg);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + erac_pkg::atan_q24(it_reg);
                end
            erac_pkg::ST_MUL:
                p_reg[mi_reg] <= prod;
            default: ;
        endcase
    end

    assign ent = ent_reg;

endmodule

// ===== rtl/core/erac_back.sv =====
`timescale 1ns / 1ps
// Back end: vertices are worked one matrix row a cycle on three
// multipliers; angle items are handed to the angle unit.
module erac_back #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_take,
    input  erac_pkg::item_t     q_item,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  rot_x,
    output logic signed [15:0]  rot_y,
    output logic signed [15:0]  rot_z
);

    localparam int FB = DATA_WIDTH - 2;
    localparam int PW = DATA_WIDTH + 17;
    localparam int SW = PW + 2;

    logic signed [DATA_WIDTH-1:0] ent [9];
    logic                         a_busy, a_done, a_start;
    logic [1:0]                   row_reg;
    logic                         vbusy_reg;
    logic signed [16:0]           v_reg [3];
    logic signed [15:0]           res_reg [3];
    logic                         ov_reg;
    logic [3:0]                   base;
    logic signed [SW-1:0]         acc, rnd, hi, lo;
    logic signed [15:0]           sat_v;

    erac_angle #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_angle
    (
        .clk(clk), .rst_n(rst_n), .start(a_start),
        .ang_x(q_item.a_x), .ang_y(q_item.a_y), .ang_z(q_item.a_z),
        .busy(a_busy), .done(a_done), .ent(ent)
    );

    wire idle   = !vbusy_reg && !a_busy;
    wire is_ang = (q_item.mode == erac_pkg::MODE_ANGLE);
    // A vertex may start in the cycle the previous result leaves.
    assign q_take  = q_valid && idle && (is_ang || !ov_reg || !out_stall);
    assign a_start = q_take && is_ang;

    always_comb
    begin
        base = {1'b0, row_reg, 1'b0} + {2'b00, row_reg};
        acc = SW'(ent[base]) * SW'(v_reg[0])
            + SW'(ent[base + 4'd1]) * SW'(v_reg[1])
            + SW'(ent[base + 4'd2]) * SW'(v_reg[2]);
        rnd = ((acc + (SW'(1) <<< (FB - 1))) >>> FB) + SW'(erac_pkg::PIVOT);
        hi  = SW'(32767);
        lo  = -SW'(32768);
        sat_v = (rnd > hi) ? 16'sh7fff : (rnd < lo) ? -16'sh8000 : 16'(rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbusy_reg <= 1'b0;
            row_reg   <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (q_take && !is_ang)
            begin
                vbusy_reg <= 1'b1;
                row_reg   <= 2'd0;
            end
            else if (vbusy_reg)
            begin
                if (row_reg == 2'd2)
                begin
                    vbusy_reg <= 1'b0;
                    ov_reg    <= 1'b1;
                end
                row_reg <= row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take && !is_ang)
        begin
            v_reg[0] <= 17'($signed(q_item.v_x)) - erac_pkg::PIVOT;
            v_reg[1] <= 17'($signed(q_item.v_y)) - erac_pkg::PIVOT;
            v_reg[2] <= 17'($signed(q_item.v_z)) - erac_pkg::PIVOT;
        end
        if (vbusy_reg)
            res_reg[row_reg] <= sat_v;
    end

    assign out_valid = ov_reg;
    assign rot_x = res_reg[0];
    assign rot_y = res_reg[1];
    assign rot_z = res_reg[2];

    a_vert_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(vbusy_reg && a_busy)) else $error("vertex and angle work overlap");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        a_done |=> !a_busy) else $error("angle unit did not return to idle");
    a_ov_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg) else $error("result dropped under stall");

endmodule

// ===== rtl/core/euler_rotate_about_center.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | mode, angle_x/y/z, vert_x/y/z
// out     | output    | out_valid / out_stall | rot_x, rot_y, rot_z
//
// A vertex beat holds the back end while it works one matrix row per cycle
// on three multipliers; its result is registered after the last row. No new
// vertex is taken before that; the next one may start in the cycle the
// previous result leaves.
// An angle beat runs through the shared CORDIC and
// the single product multiplier (steps above 24 count as 24), and gives no result.
// Reset loads the identity matrix and empties the queue and the result register.
// A two-beat queue sits between input and back end, so input keeps flowing
// while a finished result waits under out_stall, until the queue fills.
module euler_rotate_about_center #(
    parameter int DATA_WIDTH   = 16,
    parameter int CORDIC_STEPS = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    input  logic signed [15:0] vert_x,
    input  logic signed [15:0] vert_y,
    input  logic signed [15:0] vert_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] rot_x,
    output logic signed [15:0] rot_y,
    output logic signed [15:0] rot_z
);

    erac_pkg::item_t in_item, q_item;
    logic            q_valid, q_take;

    assign in_item = '{mode: mode, a_x: angle_x, a_y: angle_y, a_z: angle_z,
                       v_x: vert_x, v_y: vert_y, v_z: vert_z};

    // Front: accepts beats into the queue.
    erac_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    // Back: angle loads and vertex rotation.
    erac_back #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_item(q_item), .out_valid(out_valid), .out_stall(out_stall),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
    );

endmodule

// ===== verif/rotate_checker.sv =====
`timescale 1ns / 1ps
module rotate_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               mode,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    input  logic signed [15:0] vert_x,
    input  logic signed [15:0] vert_y,
    input  logic signed [15:0] vert_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] rot_x,
    input  logic signed [15:0] rot_y,
    input  logic signed [15:0] rot_z,
    output int                 fail_count,
    output int                 pending
);

    localparam int STEPS = 14;
    localparam int FRAC  = 14;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    longint mat [9];
    point_t rotated_q [$];

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_down(longint v, int s);
        if (s <= 0)
            return v;
        return shr_floor(v + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint mul24(longint a, longint b);
        return round_down(a * b, 24);
    endfunction

    function automatic longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint atan_entry(int i);
        longint t [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                           262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                           1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    task automatic sin_cos(input logic signed [15:0] ang, output longint c,
                           output longint s);
        longint a;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        a = longint'(ang) * 4096;
        x = 10188014;
        y = 0;
        flip = 0;
        while (a >= 52707179)
            a -= 105414357;
        while (a < -52707179)
            a += 105414357;
        // Fold into the right half plane; cosine changes sign there.
        if (a > 26353589)
        begin
            a = 52707179 - a;
            flip = 1;
        end
        else if (a < -26353589)
        begin
            a = -52707179 - a;
            flip = 1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (a >= 0)
            begin
                x -= dx;
                y += dy;
                a -= atan_entry(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                a += atan_entry(i);
            end
        end
        c = flip ? -x : x;
        s = y;
    endtask

    function automatic longint q24_to_entry(longint v);
        return clamp(round_down(v, 24 - FRAC), 16);
    endfunction

    task automatic load_angles(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az);
        longint cx, sx, cy, sy, cz, sz, czsy, szsy;
        sin_cos(ax, cx, sx);
        sin_cos(ay, cy, sy);
        sin_cos(az, cz, sz);
        czsy = mul24(cz, sy);
        szsy = mul24(sz, sy);
        mat[0] = q24_to_entry(mul24(cz, cy));
        mat[1] = q24_to_entry(mul24(czsy, sx) - mul24(sz, cx));
        mat[2] = q24_to_entry(mul24(czsy, cx) + mul24(sz, sx));
        mat[3] = q24_to_entry(mul24(sz, cy));
        mat[4] = q24_to_entry(mul24(szsy, sx) + mul24(cz, cx));
        mat[5] = q24_to_entry(mul24(szsy, cx) - mul24(cz, sx));
        mat[6] = q24_to_entry(-sy);
        mat[7] = q24_to_entry(mul24(cy, sx));
        mat[8] = q24_to_entry(mul24(cy, cx));
    endtask

    function automatic point_t rotate_point(logic signed [15:0] px, logic signed [15:0] py,
                                            logic signed [15:0] pz);
        longint v [3];
        longint acc [3];
        point_t p;
        v[0] = longint'(px) - 8192;
        v[1] = longint'(py) - 8192;
        v[2] = longint'(pz) - 8192;
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = 0;
            for (int k = 0; k < 3; k++)
                acc[r] += mat[r * 3 + k] * v[k];
            acc[r] = clamp(round_down(acc[r], FRAC) + 8192, 16);
        end
        p.x = 16'(acc[0]);
        p.y = 16'(acc[1]);
        p.z = 16'(acc[2]);
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                mat[i] = (i % 4 == 0) ? (longint'(1) << FRAC) : 0;
            rotated_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (rotated_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result beat %0d %0d %0d", rot_x, rot_y, rot_z);
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (want.x !== rot_x || want.y !== rot_y || want.z !== rot_z)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.x, want.y, want.z, rot_x, rot_y, rot_z);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode == erac_pkg::MODE_ANGLE)
                    load_angles(angle_x, angle_y, angle_z);
                else
                    rotated_q.insert(rotated_q.size(), rotate_point(vert_x, vert_y, vert_z));
            end
            pending <= rotated_q.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic mode;
    logic signed [15:0] angle_x, angle_y, angle_z;
    logic signed [15:0] vert_x, vert_y, vert_z;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] rot_x, rot_y, rot_z;
    int fail_count;
    int pending;

    // Cycle counter shared by both idling processes to place a calm stretch.
    int cycle_no;
    // Set by the sender while it wants the receiver to hold off.
    bit hold_request;

    euler_rotate_about_center u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
    );

    rotate_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        cycle_no <= cycle_no + 1;

    // Idling happens with a chance of about 21 in 100 per call, except in a calm window
    // where both sides run flat out.
    function automatic bit take_gap();
        if (cycle_no > 600 && cycle_no < 1600)
            return 0;
        return $urandom_range(99) < 21;
    endfunction

    // Receiver: random stalls, plus one long hold-off while the sender keeps
    // pushing vertices so the queue fills and in_stall rises.
    initial
    begin
        int held;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                held = 0;
                while (held < 200)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_request = 0;
            end
            out_stall <= take_gap();
        end
    end

    // Random angles lean toward the interesting range but still hit every bit.
    function automatic logic [15:0] pick_angle();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(0, 25736)) - 12868);
            1: return 16'($urandom);
            2: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'(($urandom_range(1) ? 1 : -1) * 6434
                                + $signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            default: return 16'($urandom_range(0, 16384));
        endcase
    endfunction

    // Offers one beat and waits until it is accepted. The payload holds while
    // stalled; valid stays high from one beat to the next where there is no gap.
    task automatic send_beat(input logic m, input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input logic [15:0] vx,
                             input logic [15:0] vy, input logic [15:0] vz);
        while (take_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        vert_x <= vx;
        vert_y <= vy;
        vert_z <= vz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        send_beat(erac_pkg::MODE_ANGLE, ax, ay, az,
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_vertex(input logic [15:0] vx, input logic [15:0] vy,
                               input logic [15:0] vz);
        send_beat(erac_pkg::MODE_VERTEX, 16'($urandom), 16'($urandom), 16'($urandom),
                  vx, vy, vz);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = erac_pkg::MODE_ANGLE;
        angle_x = '0;
        angle_y = '0;
        angle_z = '0;
        vert_x = '0;
        vert_y = '0;
        vert_z = '0;
        hold_request = 0;
        cycle_no = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: identity matrix on extreme points, then extreme and
        // wrapping angles, quarter turns, and points that overflow on output.
        send_vertex(16'h7FFF, 16'h8000, 16'h2000);
        send_vertex(16'h8000, 16'h7FFF, 16'h0000);
        send_angles(16'h7FFF, 16'h8000, 16'h0000);
        send_vertex(16'h4000, 16'h0000, 16'hFFFF);
        send_angles(16'h3244, 16'hCDBC, 16'h1922);
        send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vertex(16'h8000, 16'h8000, 16'h8000);
        send_angles(16'h1922, 16'h1922, 16'h1922);
        send_vertex(16'h0000, 16'h4000, 16'h2000);
        send_angles(16'hE6DE, 16'h3243, 16'h6488);
        send_vertex(16'h7FFF, 16'h0000, 16'h8000);
        send_angles(16'h0000, 16'h0000, 16'h0000);
        send_vertex(16'h1234, 16'h5678, 16'h9ABC);

        // Long hold-off: receiver stops, sender keeps offering vertices.
        hold_request = 1;
        repeat (12) send_vertex(pick_coord(), pick_coord(), pick_coord());

        // Random part: mostly vertices, an angle load now and then.
        for (int n = 0; n < 390; n++)
        begin
            if ($urandom_range(9) == 0)
                send_angles(pick_angle(), pick_angle(), pick_angle());
            else
                send_vertex(pick_coord(), pick_coord(), pick_coord());
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
